// ----- design/gf5_pkg.sv -----
// ----------------------------------------------------------------------------
// gf5_pkg: shared types and constants for the 5x5 Gaussian image filter
// Pixel and dimension widths, kernel weights, normalisation constants,
// register indexes and the pipeline record handed from the input stage.
// ----------------------------------------------------------------------------
package gf5_pkg;

   localparam int PIX_W     = 8;
   localparam int DIM_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int ROWS      = 5;
   localparam int COLS      = 5;
   localparam int KERN_W    = 4;
   localparam int COLSUM_W  = 14;
   localparam int SUM_W     = 16;
   localparam int PROD_W    = 24;

   localparam int NORM_MUL   = 32767 / 159;
   localparam int NORM_SHIFT = 15;

   localparam int MAX_WIDTH_DEF = 256;

   localparam logic [DIM_W-1:0] DIM_MIN   = 8'd5;
   localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

   localparam logic KIND_PIXEL = 1'b0;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'd1;

   typedef logic [ROWS-1:0][PIX_W-1:0]  col_type;
   typedef logic [ROWS-1:0][KERN_W-1:0] wgt_col_type;

   typedef struct packed {
      logic             shift;
      logic             emit;
      logic             border;
      logic             last;
      logic [1:0]       bank;
      logic [PIX_W-1:0] pix;
   } stage_type;

   localparam wgt_col_type KERN_EDGE = {4'd2, 4'd4, 4'd5, 4'd4, 4'd2};
   localparam wgt_col_type KERN_NEAR = {4'd4, 4'd9, 4'd12, 4'd9, 4'd4};
   localparam wgt_col_type KERN_MID  = {4'd5, 4'd12, 4'd15, 4'd12, 4'd5};

   function automatic wgt_col_type kern_column(input int column);
      wgt_col_type w;
      if (column == 0 || column == COLS - 1) begin
         w = KERN_EDGE;
      end else if (column == 1 || column == COLS - 2) begin
         w = KERN_NEAR;
      end else begin
         w = KERN_MID;
      end
      return w;
   endfunction

endpackage

// ----- design/gaussian_5x5_image_filter.sv -----
// ----------------------------------------------------------------------------
// gaussian_5x5_image_filter: streaming 5x5 Gaussian blur of grey pixels
// Raster pixels in, blurred pixels out two rows and two pixels later, frame
// border copied through, drain transfers flush the tail of the frame.
//
//   channel  direction  payload                 transfer
//   req      in         req_kind, req_pixel_in  req_valid & req_ready
//   rsp      out        rsp_pixel_out,          rsp_valid & rsp_ready
//                       rsp_frame_last
//   csr      in         csr_index, csr_data     csr_valid & csr_ready
//
// One item per cycle while the rsp side keeps the stages moving.
// The line store is four banks with one read and one write port each, read
// once per item; the window is a chain of five column cells.
// Stages hold independently; req is taken while a result waits until all fill.
// Reset clears counters and valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gaussian_5x5_image_filter #(
   parameter int MAX_WIDTH = gf5_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [gf5_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gf5_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gf5_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gf5_pkg::DIM_W-1:0]       csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int DW = gf5_pkg::DIM_W;
   localparam int PW = gf5_pkg::PIX_W;

   // configuration
   logic [DW-1:0] width_ff, width_in, height_ff, height_in;
   logic [DW-1:0] w_eff, h_eff;

   // frame position
   logic [DW-1:0] in_row_ff, in_row_in, in_col_ff, in_col_in;
   logic [DW-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [AW-1:0] in_addr_ff, in_addr_in, out_addr_ff, out_addr_in;

   // handshakes
   logic csr_xfer, req_xfer, pix_acc, flush_acc, emit, border, last;
   logic adv1, adv2, adv3;

   // pipeline
   logic               s1_valid_ff, s1_valid_in;
   gf5_pkg::stage_type s1_ff, s1_in;
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_border_ff, s2_last_ff, s2_flush_ff;
   logic [PW-1:0]      s2_store_ff;
   logic               s3_valid_ff, s3_valid_in;
   logic [gf5_pkg::SUM_W-1:0] s3_sum_ff, sum_in;
   logic               s3_border_ff, s3_last_ff;
   logic [PW-1:0]      s3_copy_ff, copy_in;
   logic               out_valid_ff, out_valid_in;
   logic [PW-1:0]      out_pixel_ff, out_pixel_in;
   logic               out_last_ff;
   logic [gf5_pkg::PROD_W-1:0] norm_prod;

   // line store and window
   logic [3:0][PW-1:0]  rd_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   gf5_pkg::col_type    col_new;
   gf5_pkg::col_type    cell_in  [gf5_pkg::COLS];
   gf5_pkg::col_type    cell_col [gf5_pkg::COLS];
   logic [gf5_pkg::COLSUM_W-1:0] cell_sum [gf5_pkg::COLS];
   logic                shift_en;

   assign w_eff = (width_ff  < gf5_pkg::DIM_MIN) ? gf5_pkg::DIM_MIN : width_ff;
   assign h_eff = (height_ff < gf5_pkg::DIM_MIN) ? gf5_pkg::DIM_MIN : height_ff;

   assign adv3      = !out_valid_ff || rsp_ready;
   assign adv2      = !s3_valid_ff || adv3;
   assign adv1      = !s2_valid_ff || adv2;
   assign req_ready = !s1_valid_ff || adv1;
   assign csr_ready = 1'b1;

   assign csr_xfer  = csr_valid && csr_ready;
   assign req_xfer  = req_valid && req_ready;
   assign pix_acc   = req_xfer && (in_row_ff < h_eff) && (req_kind == gf5_pkg::KIND_PIXEL);
   assign flush_acc = req_xfer && !(in_row_ff < h_eff);
   assign emit      = pix_acc ? ((in_row_ff > 8'd2) || (in_row_ff == 8'd2 && in_col_ff >= 8'd2))
                              : flush_acc;
   assign border    = (out_col_ff < 8'd2) || (out_row_ff < 8'd2)
                   || (out_col_ff >= w_eff - 8'd2) || (out_row_ff >= h_eff - 8'd2);
   assign last      = (out_row_ff == h_eff - 8'd1) && (out_col_ff == w_eff - 8'd1);

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_xfer) begin
         unique case (csr_index)
            gf5_pkg::CSR_WIDTH: begin
               width_in = csr_data;
            end
            gf5_pkg::CSR_HEIGHT: begin
               height_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // frame position counters
   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_addr_in  = in_addr_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_addr_in = out_addr_ff;
      if (pix_acc) begin
         if (in_col_ff >= w_eff - 8'd1) begin
            in_col_in  = '0;
            in_addr_in = '0;
            in_row_in  = in_row_ff + 8'd1;
         end else begin
            in_col_in  = in_col_ff + 8'd1;
            in_addr_in = (in_addr_ff == AW'(MAX_WIDTH - 1)) ? '0 : in_addr_ff + AW'(1);
         end
      end
      if (emit) begin
         if (last) begin
            in_row_in   = '0;
            in_col_in   = '0;
            in_addr_in  = '0;
            out_row_in  = '0;
            out_col_in  = '0;
            out_addr_in = '0;
         end else if (out_col_ff >= w_eff - 8'd1) begin
            out_col_in  = '0;
            out_addr_in = '0;
            out_row_in  = out_row_ff + 8'd1;
         end else begin
            out_col_in  = out_col_ff + 8'd1;
            out_addr_in = (out_addr_ff == AW'(MAX_WIDTH - 1)) ? '0 : out_addr_ff + AW'(1);
         end
      end
      if (csr_xfer) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_addr_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_addr_in = '0;
      end
   end

   // line store: one bank per row slot
   assign rd_en   = pix_acc || flush_acc;
   assign rd_addr = pix_acc ? in_addr_ff : out_addr_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      gf5_ram #(
         .WIDTH (PW),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (pix_acc && (in_row_ff[1:0] == 2'(b))),
         .wr_addr (in_addr_ff),
         .wr_data (req_pixel_in),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data[b])
      );
   end

   // stage 1: store data returns
   always_comb begin
      s1_in.shift  = pix_acc;
      s1_in.emit   = emit;
      s1_in.border = border;
      s1_in.last   = last;
      s1_in.bank   = pix_acc ? in_row_ff[1:0] : out_row_ff[1:0];
      s1_in.pix    = req_pixel_in;
   end

   assign s1_valid_in = pix_acc || flush_acc || (s1_valid_ff && !adv1);

   // window chain: cell 4 takes the newest column
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         col_new[i] = rd_data[2'(s1_ff.bank + 2'(i))];
      end
      col_new[4] = s1_ff.pix;
   end

   assign shift_en = s1_valid_ff && s1_ff.shift && adv1;

   for (genvar j = 0; j < gf5_pkg::COLS; j++) begin : g_cell
      if (j == gf5_pkg::COLS - 1) begin : g_head
         assign cell_in[j] = col_new;
      end else begin : g_link
         assign cell_in[j] = cell_col[j + 1];
      end
      gf5_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .col_weight (gf5_pkg::kern_column(j)),
         .col_in     (cell_in[j]),
         .col_out    (cell_col[j]),
         .colsum_out (cell_sum[j])
      );
   end

   // stage 2 to 3: add column sums, pick the copy value
   assign s2_valid_in = (s1_valid_ff && s1_ff.emit && adv1) || (s2_valid_ff && !adv2);

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < gf5_pkg::COLS; j++) begin
         sum_in = sum_in + gf5_pkg::SUM_W'(cell_sum[j]);
      end
   end

   assign copy_in     = s2_flush_ff ? s2_store_ff : cell_col[2][2];
   assign s3_valid_in = s2_valid_ff || (s3_valid_ff && !adv2);

   // stage 3 to output: normalise, or copy the border pixel
   assign norm_prod    = gf5_pkg::PROD_W'(s3_sum_ff) * gf5_pkg::PROD_W'(gf5_pkg::NORM_MUL);
   assign out_pixel_in = s3_border_ff ? s3_copy_ff : norm_prod[gf5_pkg::NORM_SHIFT +: PW];
   assign out_valid_in = s3_valid_ff || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= gf5_pkg::DIM_RESET;
         height_ff    <= gf5_pkg::DIM_RESET;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_addr_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_addr_ff   <= in_addr_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_addr_ff  <= out_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && adv1) begin
         s2_border_ff <= s1_ff.border;
         s2_last_ff   <= s1_ff.last;
         s2_flush_ff  <= !s1_ff.shift;
         s2_store_ff  <= rd_data[s1_ff.bank];
      end
      if (s2_valid_ff && adv2) begin
         s3_sum_ff    <= sum_in;
         s3_border_ff <= s2_border_ff;
         s3_last_ff   <= s2_last_ff;
         s3_copy_ff   <= copy_in;
      end
      if (s3_valid_ff && adv3) begin
         out_pixel_ff <= out_pixel_in;
         out_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = out_pixel_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

// ----- design/gf5_ram.sv -----
// ----------------------------------------------------------------------------
// gf5_ram: generic single write, single read RAM
// One write port and one read port, read data registered, old data returned
// on a read of the address being written.
// ----------------------------------------------------------------------------
module gf5_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gf5_cell.sv -----
// ----------------------------------------------------------------------------
// gf5_cell: one window column of the filter
// Holds five pixels of one column, passes them to the older neighbour on each
// shift and keeps the kernel-weighted sum of the column it holds.
// ----------------------------------------------------------------------------
module gf5_cell (
   input  logic                             clock,
   input  logic                             shift_en,
   input  gf5_pkg::wgt_col_type             col_weight,
   input  gf5_pkg::col_type                 col_in,
   output gf5_pkg::col_type                 col_out,
   output logic [gf5_pkg::COLSUM_W-1:0]     colsum_out
);

   gf5_pkg::col_type                 col_ff;
   logic [gf5_pkg::COLSUM_W-1:0]     colsum_ff;
   logic [gf5_pkg::COLSUM_W-1:0]     colsum_in;

   always_comb begin
      colsum_in = '0;
      for (int i = 0; i < gf5_pkg::ROWS; i++) begin
         colsum_in = colsum_in
                   + gf5_pkg::COLSUM_W'(col_weight[i]) * gf5_pkg::COLSUM_W'(col_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff    <= col_in;
         colsum_ff <= colsum_in;
      end
   end

   assign col_out    = col_ff;
   assign colsum_out = colsum_ff;

endmodule

// ----- sim/gaussian_5x5_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_5x5_checker: output predictor and scoreboard for the blur filter
// Watches the req, csr and rsp channels. Each req transfer is run through a
// cycle-free model of the line store, window and raster counters. Each
// predicted output pixel is queued, and each rsp transfer is compared with
// the oldest one, field by field.
// ----------------------------------------------------------------------------
module gaussian_5x5_checker #(
   parameter int STORE_W = gf5_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_kind,
   input  logic [gf5_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [gf5_pkg::PIX_W-1:0]     rsp_pixel_out,
   input  logic                          rsp_frame_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [gf5_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gf5_pkg::DIM_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending,
   output int                            results_checked,
   output int                            frames_done
);
   import gf5_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int STORE_D      = 4 * STORE_W;

   localparam logic [0:4][0:4][3:0] GAUSS_W = {
      4'd2, 4'd4,  4'd5,  4'd4,  4'd2,
      4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
      4'd5, 4'd12, 4'd15, 4'd12, 4'd5,
      4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
      4'd2, 4'd4,  4'd5,  4'd4,  4'd2
   };

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } blur_out_t;

   logic [PIX_W-1:0] line_mem [STORE_D];
   logic [PIX_W-1:0] win [5][5];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   int               in_col, in_row, out_col, out_row;
   blur_out_t        blurred_q [$];
   blur_out_t        predicted;
   blur_out_t        oldest;
   bit               made;

   task automatic blur_step(input logic kind, input logic [PIX_W-1:0] pix,
                            output bit emit, output blur_out_t res);
      int          w, h, r, c, i, j, sum;
      logic [31:0] scaled;
      w    = (width_reg < DIM_MIN) ? DIM_MIN : width_reg;
      h    = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
      emit = 1'b0;
      res  = '0;
      if (in_row < h) begin
         if (kind != KIND_PIXEL) begin
            return;
         end
         r = in_row;
         c = in_col;
         for (i = 0; i < 5; i++) begin
            for (j = 0; j < 4; j++) begin
               win[i][j] = win[i][j + 1];
            end
         end
         // rows r-4 .. r-1 sit in banks r .. r+3 modulo 4
         for (i = 0; i < 4; i++) begin
            win[i][4] = line_mem[((r + i) & 3) * STORE_W + (c % STORE_W)];
         end
         win[4][4] = pix;
         line_mem[(r & 3) * STORE_W + (c % STORE_W)] = pix;
         emit   = (r > 2) || (r == 2 && c >= 2);
         in_col = c + 1;
         if (in_col >= w) begin
            in_col = 0;
            in_row = r + 1;
         end
      end else begin
         emit = 1'b1;
      end
      if (!emit) begin
         return;
      end
      if (out_col < 2 || out_row < 2 || out_col >= w - 2 || out_row >= h - 2) begin
         res.pixel = line_mem[(out_row & 3) * STORE_W + (out_col % STORE_W)];
      end else begin
         sum = 0;
         for (i = 0; i < 5; i++) begin
            for (j = 0; j < 5; j++) begin
               sum += GAUSS_W[i][j] * win[i][j];
            end
         end
         scaled    = (sum * NORM_MUL) >> NORM_SHIFT;
         res.pixel = scaled[PIX_W-1:0];
      end
      res.last = (out_row == h - 1) && (out_col == w - 1);
      if (res.last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (line_mem[k]) line_mem[k] = '0;
         foreach (win[a, b]) win[a][b] = '0;
         width_reg       = DIM_RESET;
         height_reg      = DIM_RESET;
         in_col          = 0;
         in_row          = 0;
         out_col         = 0;
         out_row         = 0;
         blurred_q.delete();
         fail_count      = 0;
         results_checked = 0;
         frames_done     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (blurred_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("[%0t] unexpected output: pixel %0d last %0b",
                           $time, rsp_pixel_out, rsp_frame_last);
               end
               fail_count++;
            end else begin
               oldest = blurred_q.pop_front();
               if (oldest.last) begin
                  frames_done++;
               end
               if (rsp_pixel_out !== oldest.pixel || rsp_frame_last !== oldest.last) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("[%0t] output mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                              $time, oldest.pixel, rsp_pixel_out, oldest.last,
                              rsp_frame_last);
                  end
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) begin
               width_reg = csr_data;
            end else if (csr_index == CSR_HEIGHT) begin
               height_reg = csr_data;
            end
            // restart the frame on any register transfer
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
         end
         if (req_valid && req_ready) begin
            blur_step(req_kind, req_pixel_in, made, predicted);
            if (made) begin
               blurred_q.push_back(predicted);
            end
         end
      end
      pending = blurred_q.size();
   end

endmodule

// ----- sim/tb_gaussian_5x5_image_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_5x5_image_filter: stimulus and verdict for the blur filter
// Drives raster frames of random grey pixels with drain transfers, random
// sender gaps and receiver stalls. Frame sizes are reprogrammed between
// phases: a short directed frame, then many small random frames, some cut
// short. The checker beside the block predicts and compares every output
// pixel.
// ----------------------------------------------------------------------------
module tb_gaussian_5x5_image_filter;
   import gf5_pkg::*;

   localparam int   CLK_HALF      = 5;
   localparam int   RESET_CYCLES  = 4;
   localparam int   MAX_GAP       = 6;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   STALL_LIMIT   = 500;
   localparam int   RANDOM_ITEMS  = 600;
   localparam int   STORE_W       = MAX_WIDTH_DEF;
   localparam logic KIND_DRAIN    = ~KIND_PIXEL;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_kind       = KIND_PIXEL;
   logic [PIX_W-1:0]     req_pixel_in   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [PIX_W-1:0]     rsp_pixel_out;
   logic                 rsp_frame_last;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_WIDTH;
   logic [DIM_W-1:0]     csr_data       = '0;

   int fail_count, pending, results_checked, frames_done;
   int idle_cycles  = 0;
   int rsp_hold     = 0;
   bit rsp_took     = 1'b0;
   bit calm         = 1'b0;
   int pixels_sent  = 0;
   int drains_sent  = 0;
   int reg_writes   = 0;
   int useful_items = 0;
   int cols         = DIM_RESET;
   int rows         = DIM_RESET;

   gaussian_5x5_image_filter #(
      .MAX_WIDTH (STORE_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   gaussian_5x5_checker #(
      .STORE_W (STORE_W)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .frames_done     (frames_done)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      rsp_took <= rsp_valid && rsp_ready;
   end

   // after each transfer, stall the result side for a fresh random pause, none while calm
   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d outputs outstanding",
                     STALL_LIMIT, pending);
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      case ($urandom_range(0, 9))
         0:       return DIM_W'($urandom_range(0, 4));
         1:       return DIM_W'($urandom_range(13, 24));
         default: return DIM_W'($urandom_range(5, 12));
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_pixel_in <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (kind == KIND_PIXEL) begin
         pixels_sent++;
      end else begin
         drains_sent++;
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_size(input bit do_w, input bit do_h,
                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      int n;
      for (n = 0; n < 2; n++) begin
         if ((n == 0) ? do_w : do_h) begin
            csr_valid <= 1'b1;
            csr_index <= (n == 0) ? CSR_WIDTH : CSR_HEIGHT;
            csr_data  <= (n == 0) ? w : h;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            @(negedge clock);
            reg_writes++;
            if (n == 0) begin
               cols = (w < DIM_MIN) ? DIM_MIN : w;
            end else begin
               rows = (h < DIM_MIN) ? DIM_MIN : h;
            end
         end
      end
      csr_valid <= 1'b0;
   endtask

   // cut below cols*rows leaves the frame unfinished and skips the flush
   task automatic stream_frame(input int cut, input bit fixed);
      int n;
      for (n = 0; n < cut; n++) begin
         if (fixed ? (n == 7) : ($urandom_range(0, 15) == 0)) begin
            send_item(KIND_DRAIN, rand_pixel());
         end
         send_item(KIND_PIXEL, fixed ? ((n % 4 == 0) ? 8'h00 : 8'hFF) : rand_pixel());
      end
      useful_items += cut;
      if (cut == cols * rows) begin
         for (n = 0; n < 2 * cols + 2; n++) begin
            if (fixed ? (n == 3 || n == 8) : ($urandom_range(0, 3) == 0)) begin
               send_item(KIND_PIXEL, rand_pixel());
            end else begin
               send_item(KIND_DRAIN, rand_pixel());
            end
         end
         useful_items += 2 * cols + 2;
      end
   endtask

   initial begin
      int pick, frames, f, cut;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(KIND_DRAIN, 8'hFF);
      send_item(KIND_PIXEL, 8'hA5);
      quiesce();
      set_size(1'b1, 1'b1, 8'd0, 8'd4);
      send_item(KIND_DRAIN, 8'h5A);
      stream_frame(cols * rows, 1'b1);

      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         quiesce();
         pick = $urandom_range(0, 3);
         set_size(pick != 1, pick != 2, rand_dim(), rand_dim());
         calm   = ($urandom_range(0, 4) == 0);
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cols * rows - 1)
                                              : cols * rows;
            stream_frame(cut, 1'b0);
            if (cut < cols * rows) begin
               break;
            end
         end
      end

      calm = 1'b0;
      quiesce();

      $display("Covered %0d pixel and %0d drain transfers and %0d size writes,",
               pixels_sent, drains_sent, reg_writes);
      $display("checking %0d output pixels over %0d completed frames of up to 24 a side.",
               results_checked, frames_done);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/gf5_pkg.sv
design/gf5_ram.sv
design/gf5_cell.sv
design/gaussian_5x5_image_filter.sv
sim/gaussian_5x5_checker.sv
sim/tb_gaussian_5x5_image_filter.sv
